@@ rtl/rgb565_to_ycbcr420_defines.svh @@
// Assertion macros shared by the converter RTL.
`ifndef RGB565_TO_YCBCR420_DEFINES_SVH
`define RGB565_TO_YCBCR420_DEFINES_SVH

// cond must hold at every edge out of reset
`define R2Y_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define R2Y_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define R2Y_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/r2y420_pkg.sv @@
// Shared types, constants and product tables for the RGB565 to YCbCr 4:2:0 converter.
package r2y420_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int CFG_W         = 12;
  localparam int MIN_WIDTH     = 2;
  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 12'd2048;

  localparam int PROD_W  = 24;
  localparam int ACC_W   = 25;
  localparam int SUM_W   = 9;
  localparam int ENTRY_W = 2 * SUM_W;

  localparam logic [ACC_W-1:0] Y_OFFSET = 25'd1048576;
  localparam logic [ACC_W-1:0] C_OFFSET = 25'd8388608;
  localparam logic [ACC_W-1:0] C_MUL    = 25'd28672;   // 112 * 256

  typedef logic [PROD_W-1:0] prod_tab_t [256];

  typedef struct packed {
    logic odd_row;
    logic col_odd;
  } pos_t;

  // floor(cm * 256 * i / 1000) for every 8-bit i, built at elaboration
  function automatic prod_tab_t build_tab(input longint cm);
    prod_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = PROD_W'((cm * 64'd256 * longint'(i)) / 64'd1000);
    end
    return tab;
  endfunction

  localparam prod_tab_t TY_R  = build_tab(65481);
  localparam prod_tab_t TY_G  = build_tab(128553);
  localparam prod_tab_t TY_B  = build_tab(24966);
  localparam prod_tab_t TCB_R = build_tab(37797);
  localparam prod_tab_t TCB_G = build_tab(74203);
  localparam prod_tab_t TCR_G = build_tab(93786);
  localparam prod_tab_t TCR_B = build_tab(18214);

endpackage

@@ rtl/r2y420_ram.sv @@
// Generic simple dual-port RAM with registered read.
module r2y420_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/r2y420_csc.sv @@
// Color conversion stage: RGB565 expansion and BT.601 Y, Cb, Cr per pixel.
module r2y420_csc #(
  parameter int AW = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ld,
  input  logic                 in_vld,
  input  logic [15:0]          in_pixel,
  input  r2y420_pkg::pos_t     in_pos,
  input  logic [AW-1:0]        in_idx,
  output logic                 vld,
  output logic [7:0]           luma,
  output logic [7:0]           cb,
  output logic [7:0]           cr,
  output r2y420_pkg::pos_t     pos,
  output logic [AW-1:0]        idx
);

  logic [7:0] r8, g8, b8;
  logic [r2y420_pkg::ACC_W-1:0] ys, cbs, crs;

  logic                 vld_r;
  logic [7:0]           luma_r, cb_r, cr_r;
  r2y420_pkg::pos_t     pos_r;
  logic [AW-1:0]        idx_r;

  always_comb begin
    r8 = {in_pixel[15:11], in_pixel[15:13]};
    g8 = {in_pixel[10:5], in_pixel[10:9]};
    b8 = {in_pixel[4:0], in_pixel[4:2]};
    ys = r2y420_pkg::ACC_W'(r2y420_pkg::TY_R[r8])
       + r2y420_pkg::ACC_W'(r2y420_pkg::TY_G[g8])
       + r2y420_pkg::ACC_W'(r2y420_pkg::TY_B[b8])
       + r2y420_pkg::Y_OFFSET;
    // the true sums never go negative, so modular arithmetic is exact
    cbs = r2y420_pkg::C_OFFSET
        + r2y420_pkg::ACC_W'(r2y420_pkg::ACC_W'(b8) * r2y420_pkg::C_MUL)
        - r2y420_pkg::ACC_W'(r2y420_pkg::TCB_R[r8])
        - r2y420_pkg::ACC_W'(r2y420_pkg::TCB_G[g8]);
    crs = r2y420_pkg::C_OFFSET
        + r2y420_pkg::ACC_W'(r2y420_pkg::ACC_W'(r8) * r2y420_pkg::C_MUL)
        - r2y420_pkg::ACC_W'(r2y420_pkg::TCR_G[g8])
        - r2y420_pkg::ACC_W'(r2y420_pkg::TCR_B[b8]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && in_vld) begin
      luma_r <= ys[23:16];
      cb_r   <= cbs[23:16];
      cr_r   <= crs[23:16];
      pos_r  <= in_pos;
      idx_r  <= in_idx;
    end
  end

  assign vld  = vld_r;
  assign luma = luma_r;
  assign cb   = cb_r;
  assign cr   = cr_r;
  assign pos  = pos_r;
  assign idx  = idx_r;

endmodule

@@ rtl/r2y420_chroma.sv @@
// Chroma subsampling: column-pair sums in a line buffer and 2x2 averages, plus output register.
`include "rgb565_to_ycbcr420_defines.svh"

module r2y420_chroma #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             ld,
  input  logic             s2_vld,
  input  logic [7:0]       s2_luma,
  input  logic [7:0]       s2_cb,
  input  logic [7:0]       s2_cr,
  input  r2y420_pkg::pos_t s2_pos,
  input  logic [AW-1:0]    s2_idx,
  output logic             out_valid,
  output logic [7:0]       out_luma,
  output logic             out_chroma_valid,
  output logic [7:0]       out_cb,
  output logic [7:0]       out_cr
);

  logic [7:0] held_cb_r, held_cr_r;
  logic       out_valid_r, out_chroma_valid_r;
  logic [7:0] out_luma_r, out_cb_r, out_cr_r;

  logic [r2y420_pkg::SUM_W-1:0]   cb_pair, cr_pair;
  logic [r2y420_pkg::SUM_W:0]     cb_blk, cr_blk;
  logic [r2y420_pkg::ENTRY_W-1:0] wr_data, rd_data;
  logic                           wr_en, chroma_on;

  r2y420_ram #(
    .WIDTH (r2y420_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s2_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    cb_pair   = r2y420_pkg::SUM_W'(held_cb_r) + r2y420_pkg::SUM_W'(s2_cb);
    cr_pair   = r2y420_pkg::SUM_W'(held_cr_r) + r2y420_pkg::SUM_W'(s2_cr);
    cb_blk    = (r2y420_pkg::SUM_W + 1)'(rd_data[r2y420_pkg::SUM_W-1:0])
              + (r2y420_pkg::SUM_W + 1)'(cb_pair);
    cr_blk    = (r2y420_pkg::SUM_W + 1)'(rd_data[r2y420_pkg::ENTRY_W-1:r2y420_pkg::SUM_W])
              + (r2y420_pkg::SUM_W + 1)'(cr_pair);
    wr_en     = ld && s2_vld && s2_pos.col_odd && !s2_pos.odd_row;
    wr_data   = {cr_pair, cb_pair};
    chroma_on = s2_pos.col_odd && s2_pos.odd_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cb_r   <= '0;
      held_cr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld) begin
        out_valid_r <= s2_vld;
      end
      // even column: keep its chroma for the pair
      if (ld && s2_vld && !s2_pos.col_odd) begin
        held_cb_r <= s2_cb;
        held_cr_r <= s2_cr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld && s2_vld) begin
      out_luma_r         <= s2_luma;
      out_chroma_valid_r <= chroma_on;
      out_cb_r           <= chroma_on ? cb_blk[r2y420_pkg::SUM_W:2] : '0;
      out_cr_r           <= chroma_on ? cr_blk[r2y420_pkg::SUM_W:2] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_luma         = out_luma_r;
  assign out_chroma_valid = out_chroma_valid_r;
  assign out_cb           = out_cb_r;
  assign out_cr           = out_cr_r;

  `R2Y_ASSERT_NEXT(a_chroma_at_odd_pos, ld && s2_vld && chroma_on, out_valid_r && out_chroma_valid_r, "odd row odd column gave no chroma")
  `R2Y_ASSERT_IMPL(a_chroma_zero_fill, out_valid_r && !out_chroma_valid_r, out_cb_r == '0 && out_cr_r == '0, "chroma fields not zero without chroma")

endmodule

@@ rtl/rgb565_to_ycbcr420.sv @@
// Top level of the RGB565 to BT.601 YCbCr 4:2:0 converter.
//
// Input channel: in_valid/in_ready, one raster-order RGB565 pixel per transaction,
// in_frame_start marks the first pixel of a frame and restarts column and row.
// Output channel: out_valid/out_ready, one result per pixel: luma always, and
// cb/cr with out_chroma_valid on odd rows at odd columns (2x2 block average).
// cfg_wr_en/cfg_wr_data write line_width; only change it with the pipe empty.
// A result passes the input register, conversion register and output register
// after its pixel is accepted. Throughput: one pixel per cycle while out_ready
// is high, set by the single-port-per-direction line buffer (one read, one write
// per cycle) and the three pipeline registers.
// Reset: line_width returns to 2048, position to row 0 column 0. The line
// buffer is not cleared; even rows fill it before odd rows read it.
// Receiver stall: bubbles collapse, up to three pixels are held, then in_ready
// drops until out_ready returns.
`include "rgb565_to_ycbcr420_defines.svh"

module rgb565_to_ycbcr420 #(
  parameter int MAX_WIDTH = r2y420_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [r2y420_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_frame_start,
  input  logic [15:0]                  in_pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_luma,
  output logic                         out_chroma_valid,
  output logic [7:0]                   out_cb,
  output logic [7:0]                   out_cr
);

  localparam int PW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int CMPW       = (PW + 1 > r2y420_pkg::CFG_W) ? PW + 1 : r2y420_pkg::CFG_W;
  localparam logic [CMPW-1:0] MAX_W_C = CMPW'(MAX_WIDTH);
  localparam logic [CMPW-1:0] MIN_W_C = CMPW'(r2y420_pkg::MIN_WIDTH);

  logic [r2y420_pkg::CFG_W-1:0] line_width_r;
  logic [PW-1:0]                column_r, column_nxt, col_cur;
  logic                         odd_row_r, odd_row_nxt, odd_cur;
  logic [PW:0]                  col_inc;
  logic [CMPW-1:0]              lw_ext, eff_w;
  logic                         wrap, in_acc;

  logic                 s1_vld_r;
  logic [15:0]          s1_pixel_r;
  r2y420_pkg::pos_t     s1_pos_r;
  logic [AW-1:0]        s1_idx_r;

  logic                 s2_vld;
  logic [7:0]           s2_luma, s2_cb, s2_cr;
  r2y420_pkg::pos_t     s2_pos;
  logic [AW-1:0]        s2_idx;

  logic en_out, en2, en1;

  assign en_out   = !out_valid || out_ready;
  assign en2      = !s2_vld || en_out;
  assign en1      = !s1_vld_r || en2;
  assign in_ready = en1;
  assign in_acc   = in_valid && in_ready;

  // position tracking at acceptance
  always_comb begin
    col_cur = in_frame_start ? '0 : column_r;
    odd_cur = in_frame_start ? 1'b0 : odd_row_r;
    col_inc = {1'b0, col_cur} + (PW + 1)'(1);
    lw_ext  = CMPW'(line_width_r);
    if (lw_ext < MIN_W_C) begin
      eff_w = MIN_W_C;
    end else if (lw_ext > MAX_W_C) begin
      eff_w = MAX_W_C;
    end else begin
      eff_w = lw_ext;
    end
    wrap        = CMPW'(col_inc) >= eff_w;
    column_nxt  = wrap ? '0 : col_inc[PW-1:0];
    odd_row_nxt = odd_cur ^ wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= r2y420_pkg::LINE_WIDTH_RST;
      column_r     <= '0;
      odd_row_r    <= 1'b0;
      s1_vld_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        line_width_r <= cfg_wr_data;
      end
      if (in_acc) begin
        column_r  <= column_nxt;
        odd_row_r <= odd_row_nxt;
      end
      if (en1) begin
        s1_vld_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r <= in_pixel;
      s1_pos_r   <= '{odd_row: odd_cur, col_odd: col_cur[0]};
      s1_idx_r   <= AW'(col_cur >> 1);
    end
  end

  r2y420_csc #(
    .AW (AW)
  ) u_csc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (en2),
    .in_vld   (s1_vld_r),
    .in_pixel (s1_pixel_r),
    .in_pos   (s1_pos_r),
    .in_idx   (s1_idx_r),
    .vld      (s2_vld),
    .luma     (s2_luma),
    .cb       (s2_cb),
    .cr       (s2_cr),
    .pos      (s2_pos),
    .idx      (s2_idx)
  );

  // line buffer read is issued as the pixel moves into the conversion register
  r2y420_chroma #(
    .DEPTH (PAIR_DEPTH),
    .AW    (AW)
  ) u_chroma (
    .clk              (clk),
    .rst_n            (rst_n),
    .rd_en            (en2),
    .rd_addr          (s1_idx_r),
    .ld               (en_out),
    .s2_vld           (s2_vld),
    .s2_luma          (s2_luma),
    .s2_cb            (s2_cb),
    .s2_cr            (s2_cr),
    .s2_pos           (s2_pos),
    .s2_idx           (s2_idx),
    .out_valid        (out_valid),
    .out_luma         (out_luma),
    .out_chroma_valid (out_chroma_valid),
    .out_cb           (out_cb),
    .out_cr           (out_cr)
  );

  `R2Y_ASSERT_ALWAYS(a_col_bound, CMPW'(column_r) < MAX_W_C, "column beyond maximum width")
  `R2Y_ASSERT_NEXT(a_frame_start_pos, in_acc && in_frame_start, s1_idx_r == '0 && !s1_pos_r.col_odd && !s1_pos_r.odd_row, "frame start did not restart position")

endmodule

@@ tb/sv/tb_rgb565_to_ycbcr420.sv @@
// Self-checking testbench for the RGB565 to BT.601 YCbCr 4:2:0 converter.
module tb_rgb565_to_ycbcr420;

  localparam int  LINE_PAIRS     = 1024;
  localparam int  WIDTH_CAP      = 2048;
  localparam int  WIDTH_FLOOR    = 2;
  localparam int  WATCHDOG_LIMIT = 2000;
  localparam int  DRAIN_CYCLES   = 8;
  localparam int  RANDOM_ITEMS   = 1900;
  localparam int  QUIET_TAIL     = 1500;
  localparam int  MAX_REPORTS    = 10;
  localparam int  CAP_ITEMS      = 64;

  // BT.601 coefficients in thousandths, plus the fixed-point biases
  localparam longint K_Y_R   = 65481;
  localparam longint K_Y_G   = 128553;
  localparam longint K_Y_B   = 24966;
  localparam longint K_CB_R  = 37797;
  localparam longint K_CB_G  = 74203;
  localparam longint K_CR_G  = 93786;
  localparam longint K_CR_B  = 18214;
  localparam longint C_GAIN  = 28672;
  localparam longint Y_BIAS  = 1048576;
  localparam longint C_BIAS  = 8388608;

  typedef struct {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
  } ycc_t;

  class ycc_scoreboard;
    int unsigned eff_width;
    int unsigned column;
    bit          odd_row;
    logic [7:0]  held_cb;
    logic [7:0]  held_cr;
    logic [17:0] pair_sums [LINE_PAIRS];
    ycc_t        pending_ycc [$];
    int          errors;

    function new();
      eff_width = WIDTH_CAP;
      column = 0;
      odd_row = 0;
      held_cb = '0;
      held_cr = '0;
      errors = 0;
      foreach (pair_sums[i]) pair_sums[i] = '0;
    endfunction

    function void set_width(logic [11:0] w);
      eff_width = (w < WIDTH_FLOOR) ? WIDTH_FLOOR : (w > WIDTH_CAP) ? WIDTH_CAP : w;
    endfunction

    function longint scaled(longint cm, logic [7:0] v);
      return (cm * 256 * longint'(v)) / 1000;
    endfunction

    function void note_pixel(bit fs, logic [15:0] px);
      logic [7:0] r8, g8, b8, cb8, cr8;
      longint     ys, cbs, crs;
      int         idx, cb_sum, cr_sum;
      ycc_t       e;
      if (fs) begin
        column = 0;
        odd_row = 0;
      end
      r8 = {px[15:11], px[15:13]};
      g8 = {px[10:5], px[10:9]};
      b8 = {px[4:0], px[4:2]};
      ys  = scaled(K_Y_R, r8) + scaled(K_Y_G, g8) + scaled(K_Y_B, b8) + Y_BIAS;
      cbs = C_BIAS + C_GAIN * longint'(b8) - scaled(K_CB_R, r8) - scaled(K_CB_G, g8);
      crs = C_BIAS + C_GAIN * longint'(r8) - scaled(K_CR_G, g8) - scaled(K_CR_B, b8);
      e.luma = 8'(ys >> 16);
      cb8 = 8'(cbs >> 16);
      cr8 = 8'(crs >> 16);
      e.chroma_valid = 1'b0;
      e.cb = '0;
      e.cr = '0;
      idx = (column >> 1) % LINE_PAIRS;
      if (column[0] == 1'b0) begin
        held_cb = cb8;
        held_cr = cr8;
      end else if (!odd_row) begin
        cb_sum = held_cb + cb8;
        cr_sum = held_cr + cr8;
        pair_sums[idx] = {cr_sum[8:0], cb_sum[8:0]};
      end else begin
        cb_sum = pair_sums[idx][8:0] + held_cb + cb8;
        cr_sum = pair_sums[idx][17:9] + held_cr + cr8;
        e.cb = 8'(cb_sum >> 2);
        e.cr = 8'(cr_sum >> 2);
        e.chroma_valid = 1'b1;
      end
      column++;
      if (column >= eff_width) begin
        column = 0;
        odd_row = !odd_row;
      end
      pending_ycc.push_back(e);
    endfunction

    function void check_result(ycc_t got);
      ycc_t e;
      if (pending_ycc.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: luma %0d cv %0d cb %0d cr %0d",
                   got.luma, got.chroma_valid, got.cb, got.cr);
        return;
      end
      e = pending_ycc.pop_front();
      if (got.luma !== e.luma || got.chroma_valid !== e.chroma_valid ||
          got.cb !== e.cb || got.cr !== e.cr) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: exp luma %0d cv %0d cb %0d cr %0d, got luma %0d cv %0d cb %0d cr %0d",
                   e.luma, e.chroma_valid, e.cb, e.cr,
                   got.luma, got.chroma_valid, got.cb, got.cr);
      end
    endfunction

    function int pending();
      return pending_ycc.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [11:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_frame_start;
  logic [15:0] in_pixel;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_luma;
  logic        out_chroma_valid;
  logic [7:0]  out_cb;
  logic [7:0]  out_cr;

  ycc_scoreboard sb = new();
  int in_gap_pct;
  int stall_pct;
  int quiet_cycles;

  rgb565_to_ycbcr420 DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_frame_start   (in_frame_start),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_luma         (out_luma),
    .out_chroma_valid (out_chroma_valid),
    .out_cb           (out_cb),
    .out_cr           (out_cr)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stall bursts at the current rate
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct == 0 || $urandom_range(0, 99) >= stall_pct) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    ycc_t got;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pixel(in_frame_start, in_pixel);
      if (out_valid && out_ready) begin
        got.luma = out_luma;
        got.chroma_valid = out_chroma_valid;
        got.cb = out_cb;
        got.cr = out_cr;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_rgb565_to_ycbcr420 NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'hf800;
      3: return 16'h07e0;
      4: return 16'h001f;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_pixel(input bit fs, input logic [15:0] px);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_start <= fs;
    in_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_width(input logic [11:0] w);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_width(w);
  endtask

  // new width, then a frame of n pixels; a stray frame start now and then
  task automatic run_frame(input logic [11:0] w, input int n);
    wait_drained();
    write_width(w);
    for (int i = 0; i < n; i++)
      send_pixel(i == 0 || $urandom_range(0, 49) == 0, rand_pixel());
    in_valid <= 1'b0;
  endtask

  initial begin
    bit          dir_fs [15];
    logic [15:0] dir_px [15];
    int done_items;
    int w;
    int n;
    dir_fs = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1};
    dir_px = '{16'h0000, 16'hffff, 16'hf800,
               16'h07e0, 16'h001f, 16'hffff,
               16'hf800, 16'h07e0, 16'h001f,
               16'hffff, 16'hffff, 16'h0000,
               16'h0000, 16'h0000, 16'h0000};
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_frame_start = 1'b0;
    in_pixel = '0;
    in_gap_pct = 20;
    stall_pct = 20;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // a few pixels at the reset width (top row only, nothing read back)
    for (int i = 0; i < 4; i++) send_pixel(1'b0, rand_pixel());
    in_valid <= 1'b0;

    // width 3: trailing odd column, trailing odd row, frame start mid-row
    wait_drained();
    write_width(12'd3);
    for (int i = 0; i < 15; i++) send_pixel(dir_fs[i], dir_px[i]);
    in_valid <= 1'b0;

    // widths below the floor, then the all-ones value (acts as the cap)
    run_frame(12'd0, 40);
    run_frame(12'd1, 40);
    run_frame(12'hfff, CAP_ITEMS);

    done_items = 4 + 15 + 40 + 40 + CAP_ITEMS;
    while (done_items < RANDOM_ITEMS) begin
      if (done_items >= QUIET_TAIL) begin
        in_gap_pct = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: begin in_gap_pct = 0;  stall_pct = 0;  end
          1: begin in_gap_pct = 15; stall_pct = 15; end
          default: begin in_gap_pct = 40; stall_pct = 40; end
        endcase
      end
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 130) : $urandom_range(2, 24);
      n = w * $urandom_range(2, 5) + $urandom_range(0, w);
      if (n > RANDOM_ITEMS - done_items) n = RANDOM_ITEMS - done_items;
      run_frame(12'(w), n);
      done_items += n;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_rgb565_to_ycbcr420 OK");
    end else begin
      $display("tb_rgb565_to_ycbcr420 NOT OK");
    end
    $finish;
  end

endmodule

@@ rgb565_to_ycbcr420.f @@
+incdir+rtl
rtl/r2y420_pkg.sv
rtl/r2y420_ram.sv
rtl/r2y420_csc.sv
rtl/r2y420_chroma.sv
rtl/rgb565_to_ycbcr420.sv
tb/sv/tb_rgb565_to_ycbcr420.sv
